### hw/rtl/gtr_pkg.sv
// gtr_pkg: shared types, constants and font functions for the glyph text renderer.
// No dependencies; every other file but gtr_ifs imports this package.
`timescale 1ns / 1ps

package gtr_pkg;

   // Font geometry
   localparam int unsigned FONT_SLOTS   = 42;
   localparam int unsigned SLOT_W       = 6;
   localparam int unsigned GLYPH_COLS   = 5;
   localparam int unsigned NORM_ADVANCE = 6;
   localparam int unsigned DBL_ADVANCE  = 12;
   localparam int unsigned STEP_W       = 5;
   localparam logic [STEP_W-1:0] NORM_LAST_STEP = STEP_W'(NORM_ADVANCE - 1);
   localparam logic [STEP_W-1:0] DBL_LAST_STEP  = STEP_W'(4 * (DBL_ADVANCE / 2) - 1);
   localparam logic [7:0] CURSOR_MAX = 8'hFF;

   // Font slots of the first digit and letter, the punctuation marks and the blank glyph
   localparam logic [SLOT_W-1:0] SLOT_DIGIT0  = 6'd0;
   localparam logic [SLOT_W-1:0] SLOT_LETTERA = 6'd10;
   localparam logic [SLOT_W-1:0] SLOT_COLON   = 6'd36;
   localparam logic [SLOT_W-1:0] SLOT_PERIOD  = 6'd37;
   localparam logic [SLOT_W-1:0] SLOT_MINUS   = 6'd38;
   localparam logic [SLOT_W-1:0] SLOT_SLASH   = 6'd39;
   localparam logic [SLOT_W-1:0] SLOT_PERCENT = 6'd40;
   localparam logic [SLOT_W-1:0] SLOT_BLANK   = 6'd41;

   // ASCII codes recognized by the font
   localparam logic [7:0] CHAR_DIGIT0  = 8'h30;
   localparam logic [7:0] CHAR_DIGIT9  = 8'h39;
   localparam logic [7:0] CHAR_LETTERA = 8'h41;
   localparam logic [7:0] CHAR_LETTERZ = 8'h5A;
   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_PERIOD  = 8'h2E;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;

   // Command queue depth
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

   // Font ROM: column 0 in the top byte, column 4 in the bottom byte
   localparam logic [39:0] FONT_ROM [FONT_SLOTS] = '{
      40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
      40'h3649494936, 40'h064949291E, 40'h7E1111117E, 40'h7F49494936,
      40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901,
      40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100, 40'h2040413F01,
      40'h7F08142241, 40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F,
      40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
      40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
      40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543,
      40'h0036360000, 40'h0040600000, 40'h0808080808, 40'h2010080402,
      40'h2313086462, 40'h0000000000
   };

   // One glyph command passed from the front end to the write sequencer
   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [2:0]        page;
      logic [7:0]        column;
      logic              dbl;
   } cmd_type;

   // Map a character code to its font slot; unknown codes draw blank
   function automatic logic [SLOT_W-1:0] font_slot(input logic [7:0] code);
      logic [SLOT_W-1:0] slot;
      slot = SLOT_BLANK;
      if (code inside {[CHAR_DIGIT0:CHAR_DIGIT9]}) begin
         slot = SLOT_DIGIT0 + SLOT_W'(code - CHAR_DIGIT0);
      end else if (code inside {[CHAR_LETTERA:CHAR_LETTERZ]}) begin
         slot = SLOT_LETTERA + SLOT_W'(code - CHAR_LETTERA);
      end else begin
         case (code)
            CHAR_COLON:   slot = SLOT_COLON;
            CHAR_PERIOD:  slot = SLOT_PERIOD;
            CHAR_MINUS:   slot = SLOT_MINUS;
            CHAR_SLASH:   slot = SLOT_SLASH;
            CHAR_PERCENT: slot = SLOT_PERCENT;
            default:      slot = SLOT_BLANK;
         endcase
      end
      return slot;
   endfunction

   // One glyph column; columns past the glyph are blank
   function automatic logic [7:0] font_column(input logic [SLOT_W-1:0] slot,
                                              input logic [2:0] idx);
      logic [39:0] row;
      logic [7:0]  col;
      row = (slot < SLOT_W'(FONT_SLOTS)) ? FONT_ROM[slot] : 40'h0;
      case (idx)
         3'd0:    col = row[39:32];
         3'd1:    col = row[31:24];
         3'd2:    col = row[23:16];
         3'd3:    col = row[15:8];
         3'd4:    col = row[7:0];
         default: col = 8'h00;
      endcase
      return col;
   endfunction

   // Double each of the seven pixel rows vertically; bit 7 is never set
   function automatic logic [15:0] stretch(input logic [7:0] bits);
      logic [15:0] r;
      r = 16'h0;
      for (int b = 0; b < 7; b++) begin
         if (bits[b]) begin
            r[2*b]   = 1'b1;
            r[2*b+1] = 1'b1;
         end
      end
      return r;
   endfunction

endpackage

### hw/rtl/gtr_ifs.sv
// gtr_ifs: valid/ready channel interfaces for requests and frame-buffer writes.
// No dependencies.
`timescale 1ns / 1ps

interface gtr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       first_of_string;
   logic [6:0] start_column;
   logic [2:0] text_page;
   logic       double_size;

   modport source (output valid, char_code, first_of_string, start_column, text_page,
                   double_size, input ready);
   modport sink (input valid, char_code, first_of_string, start_column, text_page,
                 double_size, output ready);
endinterface

interface gtr_rsp_if;
   logic       valid;
   logic       ready;
   logic [9:0] write_address;
   logic [7:0] write_data;
   logic       last_write;

   modport source (output valid, write_address, write_data, last_write, input ready);
   modport sink (input valid, write_address, write_data, last_write, output ready);
endinterface

### hw/rtl/glyph_text_renderer_top.sv
// glyph_text_renderer_top: 5x7 font character generator feeding frame-buffer writes.
// A character passes the command queue and the command register before its first write
// is registered; the sequencer then gives one write per cycle while rsp_chan is ready,
// 6 per normal and 24 per double-size glyph; a four-entry queue decouples acceptance.
// Reset (synchronous, active high) clears cursor, page, size mode, queue and sequencer.
// Depends on gtr_pkg, gtr_ifs, gtr_front, gtr_cmd_fifo and gtr_back.
`timescale 1ns / 1ps

module glyph_text_renderer_top
   import gtr_pkg::*;
#(
   parameter int unsigned FRAME_COLUMNS = 128,
   parameter int unsigned FRAME_PAGES   = 8
) (
   input  logic       clock,
   input  logic       reset,
   gtr_req_if.sink    req_chan,
   gtr_rsp_if.source  rsp_chan
);

   logic    push, full, pop, empty;
   cmd_type push_cmd, head_cmd;

   // Front end: request acceptance and classification
   gtr_front #(
      .FRAME_COLUMNS (FRAME_COLUMNS),
      .FRAME_PAGES   (FRAME_PAGES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (full),
      .queue_push (push),
      .queue_cmd  (push_cmd)
   );

   // Command queue
   gtr_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (full),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (empty)
   );

   // Back end: write sequencing
   gtr_back #(
      .FRAME_COLUMNS (FRAME_COLUMNS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (empty),
      .queue_head  (head_cmd),
      .queue_pop   (pop),
      .rsp_chan    (rsp_chan)
   );

endmodule

### hw/rtl/gtr_front.sv
// gtr_front: accepts characters, tracks cursor/page/size, checks bounds, queues commands.
// Depends on gtr_pkg and gtr_req_if.
`timescale 1ns / 1ps

module gtr_front
   import gtr_pkg::*;
#(
   parameter int unsigned FRAME_COLUMNS = 128,
   parameter int unsigned FRAME_PAGES   = 8
) (
   input  logic       clock,
   input  logic       reset,
   gtr_req_if.sink    req_chan,
   input  logic       queue_full,
   output logic       queue_push,
   output cmd_type    queue_cmd
);

   localparam logic [8:0] NORM_MAX_COL = 9'(FRAME_COLUMNS - NORM_ADVANCE);
   localparam logic [8:0] DBL_MAX_COL  = 9'(FRAME_COLUMNS - DBL_ADVANCE);
   localparam logic [4:0] NORM_PAGES   = 5'(FRAME_PAGES);
   localparam logic [4:0] DBL_PAGES    = 5'(FRAME_PAGES - 1);

   logic [7:0] cursor_ff, cursor_in;
   logic [2:0] page_ff, page_in;
   logic       dbl_ff, dbl_in;

   logic       accept;
   logic [7:0] col_eff;
   logic [2:0] page_eff;
   logic       dbl_eff;
   logic       fits;
   logic [8:0] next_col;

   assign req_chan.ready = !queue_full;
   assign accept = req_chan.valid && req_chan.ready;

   // String settings as seen by this character
   always_comb begin
      col_eff  = req_chan.first_of_string ? {1'b0, req_chan.start_column} : cursor_ff;
      page_eff = req_chan.first_of_string ? req_chan.text_page : page_ff;
      dbl_eff  = req_chan.first_of_string ? req_chan.double_size : dbl_ff;
   end

   // Bound check and cursor advance
   always_comb begin
      if (dbl_eff) begin
         fits     = (5'(page_eff) < DBL_PAGES) && ({1'b0, col_eff} <= DBL_MAX_COL);
         next_col = {1'b0, col_eff} + 9'(DBL_ADVANCE);
      end else begin
         fits     = (5'(page_eff) < NORM_PAGES) && ({1'b0, col_eff} <= NORM_MAX_COL);
         next_col = {1'b0, col_eff} + 9'(NORM_ADVANCE);
      end
   end

   always_comb begin
      cursor_in = cursor_ff;
      page_in   = page_ff;
      dbl_in    = dbl_ff;
      if (accept) begin
         page_in = page_eff;
         dbl_in  = dbl_eff;
         if (fits) begin
            cursor_in = next_col[8] ? CURSOR_MAX : next_col[7:0];
         end else begin
            cursor_in = col_eff;
         end
      end
   end

   assign queue_push       = accept && fits;
   assign queue_cmd.slot   = font_slot(req_chan.char_code);
   assign queue_cmd.page   = page_eff;
   assign queue_cmd.column = col_eff;
   assign queue_cmd.dbl    = dbl_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= 8'h00;
         page_ff   <= 3'h0;
         dbl_ff    <= 1'b0;
      end else begin
         cursor_ff <= cursor_in;
         page_ff   <= page_in;
         dbl_ff    <= dbl_in;
      end
   end

endmodule

### hw/rtl/gtr_cmd_fifo.sv
// gtr_cmd_fifo: short register queue of glyph commands between front end and sequencer.
// Depends on gtr_pkg.
`timescale 1ns / 1ps

module gtr_cmd_fifo
   import gtr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type head_cmd,
   output logic    empty
);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### hw/rtl/gtr_back.sv
// gtr_back: write sequencer; turns each glyph command into 6 or 24 frame-buffer writes.
// Depends on gtr_pkg and gtr_rsp_if.
`timescale 1ns / 1ps

module gtr_back
   import gtr_pkg::*;
#(
   parameter int unsigned FRAME_COLUMNS = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       queue_empty,
   input  cmd_type    queue_head,
   output logic       queue_pop,
   gtr_rsp_if.source  rsp_chan
);

   logic              busy_ff, busy_in;
   cmd_type           cmd_ff, cmd_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [9:0]        addr_ff, addr_in;
   logic [7:0]        data_ff, data_in;
   logic              last_ff, last_in;

   logic              advance;
   logic              at_last;
   logic [2:0]        glyph_idx;
   logic [7:0]        glyph_byte;
   logic [15:0]       tall_byte;
   logic [3:0]        wr_page;
   logic [8:0]        wr_col;
   logic [7:0]        wr_data;
   logic [15:0]       addr_full;

   assign advance = busy_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign at_last = cmd_ff.dbl ? (step_ff == DBL_LAST_STEP) : (step_ff == NORM_LAST_STEP);

   // Decode the current step into page, column and data
   always_comb begin
      glyph_idx  = cmd_ff.dbl ? step_ff[4:2] : step_ff[2:0];
      glyph_byte = font_column(cmd_ff.slot, glyph_idx);
      tall_byte  = stretch(glyph_byte);
      if (cmd_ff.dbl) begin
         wr_page = {1'b0, cmd_ff.page} + 4'(step_ff[0]);
         wr_col  = {1'b0, cmd_ff.column} + {5'b0, step_ff[4:2], 1'b0} + 9'(step_ff[1]);
         wr_data = step_ff[0] ? tall_byte[15:8] : tall_byte[7:0];
      end else begin
         wr_page = {1'b0, cmd_ff.page};
         wr_col  = {1'b0, cmd_ff.column} + 9'(step_ff);
         wr_data = glyph_byte;
      end
      addr_full = 16'(wr_page) * 16'(FRAME_COLUMNS) + 16'(wr_col);
   end

   // Command fetch, step counter and output register
   always_comb begin
      busy_in      = busy_ff;
      cmd_in       = cmd_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      addr_in      = addr_ff;
      data_in      = data_ff;
      last_in      = last_ff;
      queue_pop    = 1'b0;
      if (advance) begin
         rsp_valid_in = 1'b1;
         addr_in      = addr_full[9:0];
         data_in      = wr_data;
         last_in      = at_last;
         if (at_last) begin
            step_in = '0;
            if (!queue_empty) begin
               queue_pop = 1'b1;
               cmd_in    = queue_head;
            end else begin
               busy_in = 1'b0;
            end
         end else begin
            step_in = step_ff + 1'b1;
         end
      end else begin
         if (rsp_chan.ready) begin
            rsp_valid_in = 1'b0;
         end
         if (!busy_ff && !queue_empty) begin
            queue_pop = 1'b1;
            cmd_in    = queue_head;
            busy_in   = 1'b1;
            step_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      addr_ff <= addr_in;
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.write_address = addr_ff;
   assign rsp_chan.write_data    = data_ff;
   assign rsp_chan.last_write    = last_ff;

endmodule

### tb/tb_glyph_text_renderer_top.sv
// tb_glyph_text_renderer_top: self-checking testbench for the 5x7 glyph text renderer.
// Depends on gtr_pkg, gtr_ifs and glyph_text_renderer_top; predicts every frame-buffer
// write in order and checks each one while both channels stall at random in most tests.
`timescale 1ns / 1ps

module tb_glyph_text_renderer_top
   import gtr_pkg::*;
();

   localparam int unsigned FRAME_COLUMNS = 128;
   localparam int unsigned FRAME_PAGES   = 8;
   localparam int unsigned MAX_REPORTS   = 10;

   // Independent copy of the font: column 0 in the top byte
   localparam logic [39:0] GLYPH_BITS [42] = '{
      40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
      40'h3649494936, 40'h064949291E, 40'h7E1111117E, 40'h7F49494936,
      40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901,
      40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100, 40'h2040413F01,
      40'h7F08142241, 40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F,
      40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
      40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
      40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543,
      40'h0036360000, 40'h0040600000, 40'h0808080808, 40'h2010080402,
      40'h2313086462, 40'h0000000000
   };

   typedef struct {
      logic [9:0] address;
      logic [7:0] data;
      logic       last;
   } fb_write_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gtr_req_if req_chan ();
   gtr_rsp_if rsp_chan ();

   glyph_text_renderer_top #(
      .FRAME_COLUMNS (FRAME_COLUMNS),
      .FRAME_PAGES   (FRAME_PAGES)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Predictor state: text cursor and latched string settings
   int unsigned pen_column;
   logic [2:0]  pen_page;
   logic        pen_double;

   fb_write_type pending_writes [$];
   int unsigned  mismatch_count = 0;
   bit           idle_enable    = 1'b1;
   bit           stall_enable   = 1'b1;

   // 100 MHz clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   // Character code to font slot; anything unsupported draws blank
   function automatic int unsigned char_slot(input logic [7:0] code);
      if (code >= CHAR_DIGIT0 && code <= CHAR_DIGIT9)
         return SLOT_DIGIT0 + (code - CHAR_DIGIT0);
      if (code >= CHAR_LETTERA && code <= CHAR_LETTERZ)
         return SLOT_LETTERA + (code - CHAR_LETTERA);
      case (code)
         CHAR_COLON:   return SLOT_COLON;
         CHAR_PERIOD:  return SLOT_PERIOD;
         CHAR_MINUS:   return SLOT_MINUS;
         CHAR_SLASH:   return SLOT_SLASH;
         CHAR_PERCENT: return SLOT_PERCENT;
         default:      return SLOT_BLANK;
      endcase
   endfunction

   // Each of the seven pixel rows becomes two rows; bit 7 is dropped
   function automatic logic [15:0] double_rows(input logic [7:0] column);
      logic [15:0] tall;
      tall = '0;
      for (int row = 0; row < 7; row++) begin
         tall[2*row +: 2] = {2{column[row]}};
      end
      return tall;
   endfunction

   function automatic void push_write(input int unsigned page, input int unsigned column,
                                      input logic [7:0] data, input bit last);
      fb_write_type w;
      w.address = 10'((page * FRAME_COLUMNS + column) & 32'h3FF);
      w.data    = data;
      w.last    = last;
      pending_writes.push_back(w);
   endfunction

   // Expected writes for one accepted request
   function automatic void render_glyph(input logic [7:0] code, input bit first,
                                        input logic [6:0] column, input logic [2:0] page,
                                        input bit dbl);
      logic [39:0] bits;
      logic [7:0]  col_byte;
      logic [15:0] tall;
      int unsigned nxt;
      int unsigned c;
      if (first) begin
         pen_column = column;
         pen_page   = page;
         pen_double = dbl;
      end
      bits = GLYPH_BITS[char_slot(code)];
      if (!pen_double) begin
         // Out of bounds: nothing drawn, cursor holds
         if (pen_page >= FRAME_PAGES || pen_column > FRAME_COLUMNS - 6) return;
         for (int i = 0; i < 6; i++) begin
            col_byte = (i < 5) ? bits[39-8*i -: 8] : 8'h00;
            push_write(pen_page, pen_column + i, col_byte, i == 5);
         end
         nxt = pen_column + 6;
      end else begin
         if (pen_page >= FRAME_PAGES - 1 || pen_column > FRAME_COLUMNS - 12) return;
         for (int i = 0; i < 6; i++) begin
            col_byte = (i < 5) ? bits[39-8*i -: 8] : 8'h00;
            tall     = double_rows(col_byte);
            c        = pen_column + 2 * i;
            push_write(pen_page,     c,     tall[7:0],  1'b0);
            push_write(pen_page + 1, c,     tall[15:8], 1'b0);
            push_write(pen_page,     c + 1, tall[7:0],  1'b0);
            push_write(pen_page + 1, c + 1, tall[15:8], i == 5);
         end
         nxt = pen_column + 12;
      end
      pen_column = (nxt > 255) ? 255 : nxt;
   endfunction

   // Mostly printable font characters, sometimes any code
   function automatic logic [7:0] pick_char();
      logic [7:0] marks [5];
      marks = '{CHAR_COLON, CHAR_PERIOD, CHAR_MINUS, CHAR_SLASH, CHAR_PERCENT};
      case ($urandom_range(0, 3))
         0:       return CHAR_DIGIT0 + 8'($urandom_range(0, 9));
         1:       return CHAR_LETTERA + 8'($urandom_range(0, 25));
         2:       return marks[$urandom_range(0, 4)];
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Send one request, with an optional idle burst ahead of it
   task automatic send_request(input logic [7:0] code, input bit first,
                               input logic [6:0] column, input logic [2:0] page,
                               input bit dbl);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_chan.valid           <= 1'b1;
      req_chan.char_code       <= code;
      req_chan.first_of_string <= first;
      req_chan.start_column    <= column;
      req_chan.text_page       <= page;
      req_chan.double_size     <= dbl;
      do @(posedge clock); while (!req_chan.ready);
      render_glyph(code, first, column, page, dbl);
   endtask

   // Continuation request: latch fields carry random values that must be ignored
   task automatic send_next(input logic [7:0] code);
      send_request(code, 1'b0, 7'($urandom), 3'($urandom), 1'($urandom));
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
   endtask

   // Requests ahead of any string start use column 0, page 0, normal size
   task automatic test_unlatched_defaults();
      send_request("8", 1'b0, 7'd127, 3'd5, 1'b1);
      send_request(8'h7F, 1'b0, 7'd64, 3'd2, 1'b1);
   endtask

   // Every punctuation mark, both ends of digits and letters, blank codes
   task automatic test_font_coverage();
      send_request(CHAR_COLON, 1'b1, 7'd0, 3'd7, 1'b0);
      send_next(CHAR_PERIOD);
      send_next(CHAR_MINUS);
      send_next(CHAR_SLASH);
      send_next(CHAR_PERCENT);
      send_next(CHAR_LETTERA);
      send_next(CHAR_LETTERZ);
      send_next(CHAR_DIGIT0);
      send_next(CHAR_DIGIT9);
      send_next(8'h00);
      send_next(8'hFF);
   endtask

   // Last column that fits, the first that does not, and a dropped string tail
   task automatic test_normal_bounds();
      send_request("W", 1'b1, 7'd122, 3'd0, 1'b0);
      send_next("X");
      send_request("Y", 1'b1, 7'd123, 3'd3, 1'b0);
      send_request("Q", 1'b1, 7'd127, 3'd7, 1'b0);
   endtask

   // Double size: fitting extremes, page and column bound failures
   task automatic test_double_size();
      send_request("M", 1'b1, 7'd116, 3'd6, 1'b1);
      send_next("N");
      send_request("B", 1'b1, 7'd0, 3'd7, 1'b1);
      send_request("K", 1'b1, 7'd117, 3'd0, 1'b1);
      send_request(CHAR_PERCENT, 1'b1, 7'd0, 3'd0, 1'b1);
   endtask

   // Strings with random content; a share are noise or out of bounds
   task automatic test_random_strings(input int unsigned count);
      int unsigned sent;
      int unsigned tail;
      logic [6:0]  column;
      logic        dbl;
      sent = 0;
      while (sent < count) begin
         dbl = ($urandom_range(0, 2) == 0);
         case ($urandom_range(0, 4))
            0:       column = 7'($urandom_range(0, 127));
            1:       column = dbl ? 7'($urandom_range(90, 116)) : 7'($urandom_range(100, 122));
            default: column = 7'($urandom_range(0, 40));
         endcase
         if ($urandom_range(0, 6) == 0) begin
            send_request(8'($urandom), 1'b1, 7'($urandom), 3'($urandom), 1'($urandom));
         end else begin
            send_request(pick_char(), 1'b1, column, 3'($urandom_range(0, 7)), dbl);
         end
         sent++;
         tail = $urandom_range(0, 7);
         for (int i = 0; i < tail && sent < count; i++) begin
            send_next(pick_char());
            sent++;
         end
      end
   endtask

   // Sender holds off until every outstanding write is out, then resumes
   task automatic test_drain_pause();
      send_request(CHAR_DIGIT9, 1'b1, 7'd10, 3'd4, 1'b1);
      wait_drained();
      send_next(CHAR_SLASH);
      send_next(8'($urandom));
   endtask

   // Back-to-back traffic with no idling on either side
   task automatic test_back_to_back();
      idle_enable  = 1'b0;
      stall_enable = 1'b0;
      test_random_strings(20);
   endtask

   // Result side: ready dropped in random stall bursts
   initial begin : sink_stalls
      int unsigned stall_left;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else if (stall_enable && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left = $urandom_range(0, 4);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Compare each accepted write with the oldest expected one
   always @(posedge clock) begin : check_writes
      fb_write_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_writes.size() == 0) begin
            if (mismatch_count < MAX_REPORTS)
               $display("unexpected write: addr=%0d data=%02h last=%0b",
                        rsp_chan.write_address, rsp_chan.write_data, rsp_chan.last_write);
            mismatch_count++;
         end else begin
            want = pending_writes.pop_front();
            if (rsp_chan.write_address !== want.address || rsp_chan.write_data !== want.data ||
                rsp_chan.last_write !== want.last) begin
               if (mismatch_count < MAX_REPORTS)
                  $display({"write mismatch: expected addr=%0d data=%02h last=%0b,",
                            " got addr=%0d data=%02h last=%0b"},
                           want.address, want.data, want.last, rsp_chan.write_address,
                           rsp_chan.write_data, rsp_chan.last_write);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : run_limit
      #5_000_000;
      $display("tb_glyph_text_renderer_top: FAIL");
      $finish;
   end

   initial begin : main_sequence
      req_chan.valid           <= 1'b0;
      req_chan.char_code       <= '0;
      req_chan.first_of_string <= 1'b0;
      req_chan.start_column    <= '0;
      req_chan.text_page       <= '0;
      req_chan.double_size     <= 1'b0;
      pen_column = 0;
      pen_page   = '0;
      pen_double = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_unlatched_defaults();
      test_font_coverage();
      test_normal_bounds();
      test_double_size();
      test_random_strings(55);
      test_drain_pause();
      test_random_strings(55);
      test_back_to_back();

      // Drain, then give the block time to show any stray write
      wait_drained();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && pending_writes.size() == 0) begin
         $display("tb_glyph_text_renderer_top: PASS");
      end else begin
         $display("tb_glyph_text_renderer_top: FAIL");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/gtr_pkg.sv
hw/rtl/gtr_ifs.sv
hw/rtl/gtr_front.sv
hw/rtl/gtr_cmd_fifo.sv
hw/rtl/gtr_back.sv
hw/rtl/glyph_text_renderer_top.sv
tb/tb_glyph_text_renderer_top.sv
